FILE: rtl/rss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_pkg: shared types and constants of the radial sector select block
// Widths, direction table constants, register codes and pipeline words.
// ----------------------------------------------------------------------------
package rss_pkg;

   // coordinate and datapath widths
   localparam int COORD_BITS = 12;
   localparam int DIFF_W     = COORD_BITS + 1;       // signed offset
   localparam int SQ_W       = 2 * COORD_BITS;       // one squared offset
   localparam int DIST_W     = SQ_W + 1;             // squared distance
   localparam int LEN_W      = COORD_BITS + 1;       // octagonal length
   localparam int HYST_W     = LEN_W + 8;            // length times factor
   localparam int PROD_W     = COORD_BITS + 11;      // offset times Q10 value
   localparam int DOT_W      = PROD_W + 1;           // sum of two products
   localparam int DIFF2_W    = DOT_W + 1;            // score difference
   localparam int RAD_W      = 8;
   localparam int RAD_SQ_W   = 2 * RAD_W;
   localparam int CNT_W      = 4;
   localparam int LANES      = 8;
   localparam int LANE_W     = 3;

   // Q10 direction components (1024 and 512 are shifts)
   localparam logic signed [10:0] K724 = 11'sd724;
   localparam logic signed [10:0] K887 = 11'sd887;
   localparam logic [7:0]         HYST_FACTOR = 8'd140;
   localparam int                 SHIFT_ONE  = 10;
   localparam int                 SHIFT_HALF = 9;

   // register port
   localparam int CSR_W     = COORD_BITS;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X     = 3'd0,
      CSR_CENTER_Y     = 3'd1,
      CSR_DEAD_RADIUS  = 3'd2,
      CSR_COMMIT_LIMIT = 3'd3,
      CSR_SECTOR_COUNT = 3'd4
   } csr_index_type;

   localparam logic [COORD_BITS-1:0] CENTER_RESET = '0;
   localparam logic [RAD_W-1:0]      DEAD_RESET   = 8'd24;
   localparam logic [RAD_W-1:0]      COMMIT_RESET = 8'd68;
   localparam logic [CNT_W-1:0]      COUNT_RESET  = 4'd8;
   localparam logic [CNT_W-1:0]      COUNT_FOUR   = 4'd4;
   localparam logic [CNT_W-1:0]      COUNT_SIX    = 4'd6;
   localparam logic [CNT_W-1:0]      COUNT_MAX    = 4'd8;
   localparam logic [CNT_W-1:0]      COUNT_MIN    = 4'd1;

   localparam logic signed [3:0] SECTOR_NONE = -4'sd1;

   // direction table in use
   typedef enum logic [1:0] {
      DIR_FOUR,
      DIR_SIX,
      DIR_EIGHT
   } dir_set_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] center_x;
      logic [COORD_BITS-1:0] center_y;
      logic [RAD_W-1:0]      dead_radius;
      logic [RAD_W-1:0]      commit_limit;
      logic [CNT_W-1:0]      sector_count;
   } cfg_type;

   // stage 1: offsets
   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [3:0]        prior;
   } st1_type;

   // stage 2: products and length
   typedef struct packed {
      logic [SQ_W-1:0]          sq_x;
      logic [SQ_W-1:0]          sq_y;
      logic signed [PROD_W-1:0] px724;
      logic signed [PROD_W-1:0] px887;
      logic signed [PROD_W-1:0] py724;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic [LEN_W-1:0]         len;
      logic signed [3:0]        prior;
   } st2_type;

   // stage 3: distance, lane scores, hysteresis margin
   typedef struct packed {
      logic [DIST_W-1:0]                  dist2;
      logic [LANES-1:0][DOT_W-1:0]        score;
      logic [HYST_W-1:0]                  hyst;
      logic signed [3:0]                  prior;
   } st3_type;

   // one candidate of the max search
   typedef struct packed {
      logic                    ok;
      logic [LANE_W-1:0]       idx;
      logic signed [DOT_W-1:0] score;
   } cand_type;

   // word carried beside the max search
   typedef struct packed {
      logic                    dead;
      logic                    commit;
      logic                    prior_ok;
      logic [LANE_W-1:0]       prior_idx;
      logic signed [DOT_W-1:0] prior_score;
      logic [HYST_W-1:0]       hyst;
   } tail_type;

   // larger score wins, lower index on a tie
   function automatic cand_type pick(input cand_type a, input cand_type b);
      cand_type r;
      if (!b.ok || (a.ok && (a.score >= b.score))) begin
         r = a;
      end else begin
         r = b;
      end
      return r;
   endfunction

endpackage

FILE: rtl/radial_sector_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_sector_select: touch direction sector quantizer with hysteresis
// Picks the direction sector of a touch around a menu center, with a dead
// zone, a commit radius and hysteresis against the previous sector.
// ----------------------------------------------------------------------------
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   ------------------------
//   request   req_touch_x, req_touch_y,               start high, busy low
//             req_prior_sector
//   response  rsp_sector, rsp_committed               rsp_valid, one cycle
//   csr       csr_index, csr_wdata                    csr_we, no wait
//
// One word enters per cycle; each result passes through the seven register
// stages (offset, products, scores, pair select, quad select, final select,
// hysteresis/output) before it is on the response ports.
// busy is always low: the response side has no stall, so nothing holds up.
// Reset is synchronous; it clears the stage valid bits and sets the configuration registers to their reset values.
//
module radial_sector_select (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [rss_pkg::COORD_BITS-1:0]  req_touch_x,
   input  logic [rss_pkg::COORD_BITS-1:0]  req_touch_y,
   input  logic signed [3:0]               req_prior_sector,
   output logic                            rsp_valid,
   output logic signed [3:0]               rsp_sector,
   output logic                            rsp_committed,
   input  logic                            csr_we,
   input  logic [rss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rss_pkg::CSR_W-1:0]       csr_wdata
);

   rss_pkg::cfg_type                 cfg_ff;
   logic [rss_pkg::RAD_SQ_W-1:0]     dead_sq_ff;
   logic [rss_pkg::RAD_SQ_W-1:0]     commit_sq_ff;
   logic [rss_pkg::CNT_W-1:0]        count_eff;
   rss_pkg::dir_set_type             dir_set;

   logic                             accept;
   logic                             s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic                             s4_vld_ff, s5_vld_ff, s6_vld_ff;
   rss_pkg::st1_type                 st1_in, st1_ff;
   rss_pkg::st2_type                 st2_in, st2_ff;
   rss_pkg::st3_type                 st3_in, st3_ff;
   rss_pkg::cand_type [3:0]          pair_in, pair_ff;
   rss_pkg::cand_type [1:0]          quad_in, quad_ff;
   rss_pkg::cand_type                best_in, best_ff;
   rss_pkg::tail_type                tail4_in, tail4_ff, tail5_ff, tail6_ff;
   logic signed [3:0]                sector_in, sector_ff;
   logic                             committed_in, committed_ff;
   logic                             rsp_valid_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x     <= rss_pkg::CENTER_RESET;
         cfg_ff.center_y     <= rss_pkg::CENTER_RESET;
         cfg_ff.dead_radius  <= rss_pkg::DEAD_RESET;
         cfg_ff.commit_limit <= rss_pkg::COMMIT_RESET;
         cfg_ff.sector_count <= rss_pkg::COUNT_RESET;
      end else if (csr_we) begin
         unique case (rss_pkg::csr_index_type'(csr_index))
            rss_pkg::CSR_CENTER_X:     cfg_ff.center_x     <= csr_wdata;
            rss_pkg::CSR_CENTER_Y:     cfg_ff.center_y     <= csr_wdata;
            rss_pkg::CSR_DEAD_RADIUS:  cfg_ff.dead_radius  <= csr_wdata[rss_pkg::RAD_W-1:0];
            rss_pkg::CSR_COMMIT_LIMIT: cfg_ff.commit_limit <= csr_wdata[rss_pkg::RAD_W-1:0];
            rss_pkg::CSR_SECTOR_COUNT: cfg_ff.sector_count <= csr_wdata[rss_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // squared radii, refreshed every cycle from the registers
   always_ff @(posedge clock) begin
      dead_sq_ff   <= cfg_ff.dead_radius * cfg_ff.dead_radius;
      commit_sq_ff <= cfg_ff.commit_limit * cfg_ff.commit_limit;
   end

   // effective count and direction table
   always_comb begin
      if (cfg_ff.sector_count == '0) begin
         count_eff = rss_pkg::COUNT_MIN;
      end else if (cfg_ff.sector_count > rss_pkg::COUNT_MAX) begin
         count_eff = rss_pkg::COUNT_MAX;
      end else begin
         count_eff = cfg_ff.sector_count;
      end
      if (count_eff == rss_pkg::COUNT_FOUR) begin
         dir_set = rss_pkg::DIR_FOUR;
      end else if (count_eff == rss_pkg::COUNT_SIX) begin
         dir_set = rss_pkg::DIR_SIX;
      end else begin
         dir_set = rss_pkg::DIR_EIGHT;
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         s4_vld_ff    <= 1'b0;
         s5_vld_ff    <= 1'b0;
         s6_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_vld_ff    <= accept;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         s4_vld_ff    <= s3_vld_ff;
         s5_vld_ff    <= s4_vld_ff;
         s6_vld_ff    <= s5_vld_ff;
         rsp_valid_ff <= s6_vld_ff;
      end
   end

   // stage 1: offset from center
   always_comb begin
      st1_in.dx    = $signed({1'b0, req_touch_x}) - $signed({1'b0, cfg_ff.center_x});
      st1_in.dy    = $signed({1'b0, req_touch_y}) - $signed({1'b0, cfg_ff.center_y});
      st1_in.prior = req_prior_sector;
   end

   // stage 2: squares, scaled offsets, octagonal length
   always_comb begin
      logic [rss_pkg::COORD_BITS-1:0] ax;
      logic [rss_pkg::COORD_BITS-1:0] ay;
      logic [rss_pkg::COORD_BITS-1:0] big;
      logic [rss_pkg::COORD_BITS-1:0] sml;
      ax = rss_pkg::COORD_BITS'(st1_ff.dx[rss_pkg::DIFF_W-1] ? -st1_ff.dx : st1_ff.dx);
      ay = rss_pkg::COORD_BITS'(st1_ff.dy[rss_pkg::DIFF_W-1] ? -st1_ff.dy : st1_ff.dy);
      big = (ax > ay) ? ax : ay;
      sml = (ax > ay) ? ay : ax;
      st2_in.sq_x  = rss_pkg::SQ_W'(st1_ff.dx * st1_ff.dx);
      st2_in.sq_y  = rss_pkg::SQ_W'(st1_ff.dy * st1_ff.dy);
      st2_in.px724 = rss_pkg::PROD_W'(st1_ff.dx * rss_pkg::K724);
      st2_in.px887 = rss_pkg::PROD_W'(st1_ff.dx * rss_pkg::K887);
      st2_in.py724 = rss_pkg::PROD_W'(st1_ff.dy * rss_pkg::K724);
      st2_in.dx    = st1_ff.dx;
      st2_in.dy    = st1_ff.dy;
      st2_in.len   = rss_pkg::LEN_W'(big) + rss_pkg::LEN_W'(sml >> 1);
      st2_in.prior = st1_ff.prior;
   end

   // stage 3: distance, lane dot products, hysteresis margin
   always_comb begin
      logic signed [rss_pkg::DOT_W-1:0] x1k;
      logic signed [rss_pkg::DOT_W-1:0] y1k;
      logic signed [rss_pkg::DOT_W-1:0] y512;
      logic signed [rss_pkg::DOT_W-1:0] x724;
      logic signed [rss_pkg::DOT_W-1:0] y724;
      logic signed [rss_pkg::DOT_W-1:0] x887;
      x1k  = rss_pkg::DOT_W'(st2_ff.dx) <<< rss_pkg::SHIFT_ONE;
      y1k  = rss_pkg::DOT_W'(st2_ff.dy) <<< rss_pkg::SHIFT_ONE;
      y512 = rss_pkg::DOT_W'(st2_ff.dy) <<< rss_pkg::SHIFT_HALF;
      x724 = rss_pkg::DOT_W'(st2_ff.px724);
      y724 = rss_pkg::DOT_W'(st2_ff.py724);
      x887 = rss_pkg::DOT_W'(st2_ff.px887);
      st3_in.dist2 = rss_pkg::DIST_W'(st2_ff.sq_x) + rss_pkg::DIST_W'(st2_ff.sq_y);
      st3_in.hyst  = rss_pkg::HYST_W'(st2_ff.len * rss_pkg::HYST_FACTOR);
      st3_in.prior = st2_ff.prior;
      st3_in.score = '0;
      unique case (dir_set)
         rss_pkg::DIR_FOUR: begin
            st3_in.score[0] = -y1k;
            st3_in.score[1] = x1k;
            st3_in.score[2] = y1k;
            st3_in.score[3] = -x1k;
         end
         rss_pkg::DIR_SIX: begin
            st3_in.score[0] = -y1k;
            st3_in.score[1] = x887 - y512;
            st3_in.score[2] = x887 + y512;
            st3_in.score[3] = y1k;
            st3_in.score[4] = y512 - x887;
            st3_in.score[5] = -x887 - y512;
         end
         default: begin
            st3_in.score[0] = -y1k;
            st3_in.score[1] = x724 - y724;
            st3_in.score[2] = x1k;
            st3_in.score[3] = x724 + y724;
            st3_in.score[4] = y1k;
            st3_in.score[5] = y724 - x724;
            st3_in.score[6] = -x1k;
            st3_in.score[7] = -x724 - y724;
         end
      endcase
   end

   // stage 4: radius compares, prior lookup, pairwise select
   always_comb begin
      rss_pkg::cand_type [rss_pkg::LANES-1:0] lane;
      for (int i = 0; i < rss_pkg::LANES; i++) begin
         lane[i].ok    = rss_pkg::CNT_W'(i) < count_eff;
         lane[i].idx   = rss_pkg::LANE_W'(i);
         lane[i].score = st3_ff.score[i];
      end
      for (int p = 0; p < 4; p++) begin
         pair_in[p] = rss_pkg::pick(lane[2*p], lane[2*p+1]);
      end
      tail4_in.dead        = st3_ff.dist2 <= rss_pkg::DIST_W'(dead_sq_ff);
      tail4_in.commit      = st3_ff.dist2 >= rss_pkg::DIST_W'(commit_sq_ff);
      tail4_in.prior_idx   = st3_ff.prior[rss_pkg::LANE_W-1:0];
      tail4_in.prior_ok    = !st3_ff.prior[3] &&
                             ({1'b0, st3_ff.prior[rss_pkg::LANE_W-1:0]} < count_eff);
      tail4_in.prior_score = st3_ff.score[st3_ff.prior[rss_pkg::LANE_W-1:0]];
      tail4_in.hyst        = st3_ff.hyst;
   end

   // stages 5 and 6: rest of the select tree
   always_comb begin
      quad_in[0] = rss_pkg::pick(pair_ff[0], pair_ff[1]);
      quad_in[1] = rss_pkg::pick(pair_ff[2], pair_ff[3]);
      best_in    = rss_pkg::pick(quad_ff[0], quad_ff[1]);
   end

   // stage 7: hysteresis against the prior sector, dead zone
   always_comb begin
      logic signed [rss_pkg::DIFF2_W-1:0] gain;
      logic signed [rss_pkg::DIFF2_W-1:0] margin;
      logic                               keep;
      gain   = rss_pkg::DIFF2_W'(best_ff.score) - rss_pkg::DIFF2_W'(tail6_ff.prior_score);
      margin = $signed({{(rss_pkg::DIFF2_W-rss_pkg::HYST_W){1'b0}}, tail6_ff.hyst});
      keep   = tail6_ff.commit && tail6_ff.prior_ok &&
               (tail6_ff.prior_idx != best_ff.idx) && (gain < margin);
      if (tail6_ff.dead) begin
         sector_in    = rss_pkg::SECTOR_NONE;
         committed_in = 1'b0;
      end else begin
         sector_in    = $signed({1'b0, keep ? tail6_ff.prior_idx : best_ff.idx});
         committed_in = tail6_ff.commit;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      st1_ff       <= st1_in;
      st2_ff       <= st2_in;
      st3_ff       <= st3_in;
      pair_ff      <= pair_in;
      tail4_ff     <= tail4_in;
      quad_ff      <= quad_in;
      tail5_ff     <= tail4_ff;
      best_ff      <= best_in;
      tail6_ff     <= tail5_ff;
      sector_ff    <= sector_in;
      committed_ff <= committed_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sector    = sector_ff;
   assign rsp_committed = committed_ff;

   // every word that enters the first stage later comes out on rsp_valid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |-> ##6 rsp_valid)
      else $error("response missing after request");

   // a selected sector lies inside the active direction count
   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_sector != rss_pkg::SECTOR_NONE)) |->
      ({1'b0, rsp_sector[2:0]} < count_eff) && !rsp_sector[3])
      else $error("sector outside direction count");

   // dead zone results never commit
   a_dead_commit: assert property (@(posedge clock) disable iff (reset)
      (s6_vld_ff && tail6_ff.dead) |=> (rsp_valid && !rsp_committed &&
      (rsp_sector == rss_pkg::SECTOR_NONE)))
      else $error("dead zone word committed");

endmodule
